// ----- src/assert_macros.svh -----
// Assertion macros shared by the serial command line parser RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define SCLP_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define SCLP_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- src/sclp_pkg.sv -----
// Types, codes and constants of the serial command line parser.
`timescale 1ns / 1ps
package sclp_pkg;

	localparam int LINE_CAP_DEF = 24;

	localparam int VALUE_W = 32;
	localparam int WHOLE_W = 25;

	localparam logic [VALUE_W-1:0] MAG_CAP = 32'h8000_0000;
	localparam logic [VALUE_W-1:0] POS_MAX = 32'h7FFF_FFFF;

	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_MINUS  = 8'h2D;
	localparam logic [7:0] CH_POINT  = 8'h2E;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_NINE   = 8'h39;
	localparam logic [7:0] CH_REPORT = 8'h3F;
	localparam logic [7:0] CH_KP     = 8'h70;
	localparam logic [7:0] CH_KD     = 8'h64;
	localparam logic [7:0] CH_VKP    = 8'h76;
	localparam logic [7:0] CH_VKI    = 8'h69;
	localparam logic [7:0] CH_LOADED = 8'h6C;
	localparam logic [7:0] CH_EMPTY  = 8'h65;
	localparam logic [7:0] CH_FORCE  = 8'h6D;
	localparam logic [7:0] CH_TELEM  = 8'h74;

	localparam logic [3:0] TGT_KP        = 4'd0;
	localparam logic [3:0] TGT_KD        = 4'd1;
	localparam logic [3:0] TGT_VKP       = 4'd2;
	localparam logic [3:0] TGT_VKI       = 4'd3;
	localparam logic [3:0] TGT_HEAVY_OFS = 4'd4;
	localparam logic [3:0] TGT_LOADED    = 4'd8;
	localparam logic [3:0] TGT_EMPTY     = 4'd9;
	localparam logic [3:0] TGT_FORCE     = 4'd10;
	localparam logic [3:0] TGT_TELEM     = 4'd11;
	localparam logic [3:0] TGT_NONE      = 4'd0;

	localparam logic [VALUE_W-1:0] MODE_ONE = 32'd1;
	localparam logic [VALUE_W-1:0] MODE_TWO = 32'd2;

	typedef enum logic [1:0] {
		ST_WRITE_OK     = 2'd0,
		ST_WRITE_SILENT = 2'd1,
		ST_REPORT       = 2'd2,
		ST_UNKNOWN      = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		PH_SPACES = 2'd0,
		PH_WHOLE  = 2'd1,
		PH_FRAC   = 2'd2,
		PH_DONE   = 2'd3
	} phase_t;

	typedef struct packed {
		phase_t               phase;
		logic                 neg;
		logic [VALUE_W-1:0]   accum;
		logic [WHOLE_W-1:0]   whole;
		logic [1:0]           frac_cnt;
	} parse_t;

	localparam parse_t PARSE_CLEAR = '{
		phase:    PH_SPACES,
		neg:      1'b0,
		accum:    '0,
		whole:    '0,
		frac_cnt: 2'd0
	};

endpackage

// ----- src/sclp_if.sv -----
// Valid/ready channels of the parser: received bytes in, results out.
`timescale 1ns / 1ps
interface sclp_rx_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;
	logic       heavy_detected;

	modport source (output valid, output rx_byte, output heavy_detected, input ready);
	modport sink (input valid, input rx_byte, input heavy_detected, output ready);
endinterface

interface sclp_res_if;
	logic        valid;
	logic        ready;
	logic [1:0]  status;
	logic [3:0]  target;
	logic signed [31:0] value;

	modport source (output valid, output status, output target, output value, input ready);
	modport sink (input valid, input status, input target, input value, output ready);
endinterface

// ----- src/serial_command_line_parser_unit.sv -----
// Top level of the serial command line parser: line state, command decode, result register.
`timescale 1ns / 1ps
// Takes one received byte per beat and returns one result beat for each non-empty line
// closed by CR or LF. A byte is taken every cycle but for the stall below; it is held in the
// input register, and its result, if any, is loaded from there into the result register,
// from which the result beat is offered. The only stall is a line-ending byte that meets
// a result still waiting in the result register: the input holds until that result is
// taken. The command is the first byte of the line, the number after it is parsed as it
// arrives, and bytes past LINE_CAP-1 are dropped. Force and telemetry modes persist across
// lines; heavy_detected is sampled with the line-ending byte.
module serial_command_line_parser_unit #(
	parameter int LINE_CAP = sclp_pkg::LINE_CAP_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	sclp_rx_if.sink         rx,
	sclp_res_if.source      res
);
	import sclp_pkg::*;
	`include "assert_macros.svh"

	localparam int LEN_W = $clog2(LINE_CAP);
	localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(LINE_CAP - 1);

	logic               valid_s1;
	logic [7:0]         rx_byte_s1;
	logic               heavy_s1;

	logic [LEN_W-1:0]   line_len_q;
	logic [7:0]         cmd_q;
	parse_t             parse_q;
	parse_t             parse_nxt;
	logic               force1_q;
	logic               force2_q;
	logic               telem2_q;

	logic               res_valid_q;
	status_t            res_status_q;
	logic [3:0]         res_target_q;
	logic [VALUE_W-1:0] res_value_q;

	logic               eol_s1;
	logic               line_end;
	logic               s1_adv;
	logic               s1_go;
	logic               res_load;
	logic               sat;
	logic [VALUE_W-1:0] limit;
	logic [VALUE_W-1:0] whole_mag;
	logic [VALUE_W-1:0] hund;
	logic [VALUE_W-1:0] intv;
	logic [3:0]         base;
	status_t            status_c;
	logic [3:0]         target_c;
	logic [VALUE_W-1:0] value_c;
	logic               force1_c;
	logic               force2_c;
	logic               telem2_c;

	sclp_parse u_parse (
		.rx_byte (rx_byte_s1),
		.cur     (parse_q),
		.nxt     (parse_nxt)
	);

	assign eol_s1   = (rx_byte_s1 == CH_CR) || (rx_byte_s1 == CH_LF);
	assign line_end = eol_s1 && (line_len_q != '0);
	assign s1_adv   = !line_end || !res_valid_q || res.ready;
	assign s1_go    = valid_s1 && s1_adv;
	assign res_load = s1_go && line_end;
	assign rx.ready = !valid_s1 || s1_adv;

	always_comb begin
		sat       = (parse_q.accum == MAG_CAP);
		limit     = parse_q.neg ? MAG_CAP : POS_MAX;
		whole_mag = VALUE_W'(parse_q.whole);
		hund      = sat ? limit : (parse_q.neg ? (~parse_q.accum + 1'b1) : parse_q.accum);
		intv      = sat ? limit : (parse_q.neg ? (~whole_mag + 1'b1) : whole_mag);

		if (force1_q) begin
			base = 4'd0;
		end else if (force2_q) begin
			base = TGT_HEAVY_OFS;
		end else begin
			base = heavy_s1 ? TGT_HEAVY_OFS : 4'd0;
		end

		status_c = ST_WRITE_OK;
		target_c = TGT_NONE;
		value_c  = '0;
		force1_c = force1_q;
		force2_c = force2_q;
		telem2_c = telem2_q;
		case (cmd_q)
			CH_REPORT: begin
				status_c = ST_REPORT;
			end
			CH_KP: begin
				target_c = base + TGT_KP;
				value_c  = hund;
			end
			CH_KD: begin
				target_c = base + TGT_KD;
				value_c  = hund;
			end
			CH_VKP: begin
				target_c = base + TGT_VKP;
				value_c  = hund;
			end
			CH_VKI: begin
				target_c = base + TGT_VKI;
				value_c  = hund;
			end
			CH_LOADED: begin
				target_c = TGT_LOADED;
				value_c  = hund;
			end
			CH_EMPTY: begin
				target_c = TGT_EMPTY;
				value_c  = hund;
			end
			CH_FORCE: begin
				target_c = TGT_FORCE;
				value_c  = intv;
				force1_c = (intv == MODE_ONE);
				force2_c = (intv == MODE_TWO);
			end
			CH_TELEM: begin
				target_c = TGT_TELEM;
				value_c  = intv;
				telem2_c = (intv == MODE_TWO);
			end
			default: begin
				status_c = ST_UNKNOWN;
			end
		endcase
		if (status_c == ST_WRITE_OK && telem2_c) begin
			status_c = ST_WRITE_SILENT;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx.ready) begin
			valid_s1 <= rx.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rx.valid && rx.ready) begin
			rx_byte_s1 <= rx.rx_byte;
			heavy_s1   <= rx.heavy_detected;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_len_q <= '0;
			cmd_q      <= '0;
			parse_q    <= PARSE_CLEAR;
			force1_q   <= 1'b0;
			force2_q   <= 1'b0;
			telem2_q   <= 1'b0;
		end else if (s1_go) begin
			if (eol_s1) begin
				if (line_end) begin
					line_len_q <= '0;
					cmd_q      <= '0;
					parse_q    <= PARSE_CLEAR;
					force1_q   <= force1_c;
					force2_q   <= force2_c;
					telem2_q   <= telem2_c;
				end
			end else if (line_len_q < LEN_MAX) begin
				if (line_len_q == '0) begin
					cmd_q <= rx_byte_s1;
				end else begin
					parse_q <= parse_nxt;
				end
				line_len_q <= line_len_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (res_load) begin
			res_valid_q <= 1'b1;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			res_status_q <= status_c;
			res_target_q <= target_c;
			res_value_q  <= value_c;
		end
	end

	assign res.valid  = res_valid_q;
	assign res.status = res_status_q;
	assign res.target = res_target_q;
	assign res.value  = res_value_q;

	`SCLP_ASSERT_NEXT(a_clear_after_line, res_load, (line_len_q == '0) && (parse_q.phase == PH_SPACES), "line state not cleared after a result")
	`SCLP_ASSERT_SAME(a_accum_capped, 1'b1, parse_q.accum <= MAG_CAP, "magnitude above saturation cap")
	`SCLP_ASSERT_SAME(a_silent_needs_telem, res_valid_q && (res_status_q == ST_WRITE_SILENT), telem2_q, "silent write without telemetry mode two")
	`SCLP_ASSERT_SAME(a_no_payload_on_report, res_valid_q && ((res_status_q == ST_REPORT) || (res_status_q == ST_UNKNOWN)), (res_target_q == TGT_NONE) && (res_value_q == '0), "report or unknown beat carries a payload")
	`SCLP_ASSERT_SAME(a_empty_stage_ready, !valid_s1, rx.ready, "input stalled with an empty input register")
endmodule

// ----- src/sclp_parse.sv -----
// One-byte step of the number parser: hundredths and integer part, saturating.
`timescale 1ns / 1ps
module sclp_parse (
	input  logic [7:0]      rx_byte,
	input  sclp_pkg::parse_t cur,
	output sclp_pkg::parse_t nxt
);
	import sclp_pkg::*;

	logic                 dig;
	logic [3:0]           d;
	logic [35:0]          whole_sum;
	logic [VALUE_W-1:0]   whole_accum;
	logic [WHOLE_W+3:0]   whole_ext;
	logic [7:0]           frac_add;
	logic [VALUE_W:0]     frac_sum;
	logic [VALUE_W-1:0]   frac_accum;

	always_comb begin
		dig = rx_byte inside {[CH_ZERO:CH_NINE]};
		d = dig ? rx_byte[3:0] : 4'd0;

		whole_sum = (36'(cur.accum) << 3) + (36'(cur.accum) << 1) + 36'(d) * 36'd100;
		whole_accum = (whole_sum > 36'(MAG_CAP)) ? MAG_CAP : whole_sum[VALUE_W-1:0];
		whole_ext = ((WHOLE_W+4)'(cur.whole) << 3) + ((WHOLE_W+4)'(cur.whole) << 1)
			+ (WHOLE_W+4)'(d);

		frac_add = (cur.frac_cnt == 2'd0) ? 8'(d) * 8'd10 : 8'(d);
		frac_sum = (VALUE_W+1)'(cur.accum) + (VALUE_W+1)'(frac_add);
		frac_accum = (frac_sum > (VALUE_W+1)'(MAG_CAP)) ? MAG_CAP : frac_sum[VALUE_W-1:0];

		nxt = cur;
		case (cur.phase)
			PH_SPACES: begin
				if (rx_byte == CH_SPACE) begin
					nxt.phase = PH_SPACES;
				end else if (rx_byte == CH_MINUS) begin
					nxt.neg = 1'b1;
					nxt.phase = PH_WHOLE;
				end else if (dig) begin
					nxt.accum = whole_accum;
					nxt.whole = whole_ext[WHOLE_W-1:0];
					nxt.phase = PH_WHOLE;
				end else if (rx_byte == CH_POINT) begin
					nxt.phase = PH_FRAC;
				end else begin
					nxt.phase = PH_DONE;
				end
			end
			PH_WHOLE: begin
				if (dig) begin
					nxt.accum = whole_accum;
					nxt.whole = whole_ext[WHOLE_W-1:0];
				end else if (rx_byte == CH_POINT) begin
					nxt.phase = PH_FRAC;
				end else begin
					nxt.phase = PH_DONE;
				end
			end
			PH_FRAC: begin
				if (!dig) begin
					nxt.phase = PH_DONE;
				end else if (cur.frac_cnt != 2'd2) begin
					nxt.accum = frac_accum;
					nxt.frac_cnt = cur.frac_cnt + 2'd1;
				end
			end
			default: begin
				nxt = cur;
			end
		endcase
	end
endmodule

// ----- tb/tb.sv -----
// Testbench of the serial command line parser: directed and random lines checked against a predictor.
`timescale 1ns / 1ps
module tb;
	import sclp_pkg::*;

	localparam int CAP = LINE_CAP_DEF;
	localparam int RANDOM_ITEMS = 1600;
	localparam int LONG_HOLD = 64;
	localparam int SETTLE_CYCLES = 10;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int DIR_ROWS = 26;

	localparam logic [7:0] CMD_SET [10] = '{CH_REPORT, CH_KP, CH_KD, CH_VKP, CH_VKI,
		CH_LOADED, CH_EMPTY, CH_FORCE, CH_TELEM, CH_KP};

	typedef struct packed {
		status_t            status;
		logic [3:0]         target;
		logic signed [31:0] value;
	} res_t;

	typedef struct {
		string       text;
		logic [7:0]  term;
		logic        heavy;
		bit          typed;
		status_t     st;
		logic [3:0]  tgt;
		logic [31:0] val;
	} dir_row_t;

	dir_row_t dir_tab [DIR_ROWS] = '{
		'{"?", CH_CR, 1'b0, 1'b1, ST_REPORT, TGT_NONE, 32'd0},
		'{"", CH_LF, 1'b0, 1'b0, ST_WRITE_OK, TGT_NONE, 32'd0},
		'{"x12", CH_LF, 1'b1, 1'b1, ST_UNKNOWN, TGT_NONE, 32'd0},
		'{"p1.5", CH_CR, 1'b0, 1'b1, ST_WRITE_OK, TGT_KP, 32'd150},
		'{"d -2.345", CH_LF, 1'b1, 1'b0, ST_WRITE_OK, TGT_NONE, 32'd0},
		'{"v.07", CH_CR, 1'b0, 1'b0, ST_WRITE_OK, TGT_NONE, 32'd0},
		'{"i12x5", CH_CR, 1'b1, 1'b0, ST_WRITE_OK, TGT_NONE, 32'd0},
		'{"l- 5", CH_LF, 1'b0, 1'b0, ST_WRITE_OK, TGT_NONE, 32'd0},
		'{"e3 4", CH_CR, 1'b0, 1'b0, ST_WRITE_OK, TGT_NONE, 32'd0},
		'{"p--1", CH_CR, 1'b0, 1'b0, ST_WRITE_OK, TGT_NONE, 32'd0},
		'{"p1.2.3", CH_CR, 1'b0, 1'b0, ST_WRITE_OK, TGT_NONE, 32'd0},
		'{"p.1234", CH_LF, 1'b0, 1'b0, ST_WRITE_OK, TGT_NONE, 32'd0},
		'{"p99999999999", CH_CR, 1'b0, 1'b1, ST_WRITE_OK, TGT_KP, POS_MAX},
		'{"p-99999999999", CH_LF, 1'b1, 1'b1, ST_WRITE_OK, TGT_HEAVY_OFS + TGT_KP, MAG_CAP},
		'{"p21474836.48", CH_CR, 1'b0, 1'b0, ST_WRITE_OK, TGT_NONE, 32'd0},
		'{"i-21474836.47", CH_CR, 1'b1, 1'b0, ST_WRITE_OK, TGT_NONE, 32'd0},
		'{"p                     12", CH_CR, 1'b0, 1'b0, ST_WRITE_OK, TGT_NONE, 32'd0},
		'{"m1", CH_CR, 1'b0, 1'b1, ST_WRITE_OK, TGT_FORCE, 32'd1},
		'{"p5", CH_LF, 1'b1, 1'b0, ST_WRITE_OK, TGT_NONE, 32'd0},
		'{"m2.9", CH_CR, 1'b0, 1'b1, ST_WRITE_OK, TGT_FORCE, 32'd2},
		'{"v3", CH_CR, 1'b0, 1'b0, ST_WRITE_OK, TGT_NONE, 32'd0},
		'{"m-99999999999", CH_CR, 1'b1, 1'b1, ST_WRITE_OK, TGT_FORCE, MAG_CAP},
		'{"d7", CH_CR, 1'b1, 1'b0, ST_WRITE_OK, TGT_NONE, 32'd0},
		'{"t2", CH_LF, 1'b0, 1'b1, ST_WRITE_SILENT, TGT_TELEM, 32'd2},
		'{"?", CH_CR, 1'b0, 1'b1, ST_REPORT, TGT_NONE, 32'd0},
		'{"t0", CH_CR, 1'b0, 1'b1, ST_WRITE_OK, TGT_TELEM, 32'd0}
	};

	logic clk = 1'b0;
	logic arst_n;

	sclp_rx_if rx_ch ();
	sclp_res_if res_ch ();

	serial_command_line_parser_unit #(
		.LINE_CAP(CAP)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.rx(rx_ch),
		.res(res_ch)
	);

	always #1 clk = ~clk;

	// line state of the predictor
	int unsigned line_len;
	logic [7:0] cmd_char;
	phase_t parse_ph;
	logic neg_flag;
	logic [31:0] mag;
	logic [1:0] frac_cnt;
	logic [31:0] force_md;
	logic [31:0] telem_md;

	res_t line_results_q [$];
	bit use_typed;
	res_t typed_res;
	int err_cnt;
	int sent_cnt;
	bit hold_req;
	bit tx_idle_on;
	bit rx_idle_on;
	int idle_cycles;

	function automatic logic [31:0] sat_mag(input logic [63:0] x);
		return (x > {32'd0, MAG_CAP}) ? MAG_CAP : x[31:0];
	endfunction

	function automatic logic [31:0] apply_sign(input logic [31:0] m);
		if (neg_flag) begin
			return (m >= MAG_CAP) ? MAG_CAP : 32'd0 - m;
		end
		return (m >= MAG_CAP) ? POS_MAX : m;
	endfunction

	function automatic void clear_line();
		line_len = 0;
		cmd_char = '0;
		parse_ph = PH_SPACES;
		neg_flag = 1'b0;
		mag = '0;
		frac_cnt = '0;
	endfunction

	function automatic void step_number(input logic [7:0] b);
		bit is_dig;
		logic [63:0] d;
		is_dig = (b >= CH_ZERO) && (b <= CH_NINE);
		d = is_dig ? 64'(b - CH_ZERO) : 64'd0;
		case (parse_ph)
			PH_SPACES: begin
				if (b == CH_SPACE) begin
				end else if (b == CH_MINUS) begin
					neg_flag = 1'b1;
					parse_ph = PH_WHOLE;
				end else if (is_dig) begin
					mag = sat_mag({32'd0, mag} * 10 + d * 100);
					parse_ph = PH_WHOLE;
				end else if (b == CH_POINT) begin
					parse_ph = PH_FRAC;
				end else begin
					parse_ph = PH_DONE;
				end
			end
			PH_WHOLE: begin
				if (is_dig) mag = sat_mag({32'd0, mag} * 10 + d * 100);
				else if (b == CH_POINT) parse_ph = PH_FRAC;
				else parse_ph = PH_DONE;
			end
			PH_FRAC: begin
				if (!is_dig) begin
					parse_ph = PH_DONE;
				end else if (frac_cnt == 2'd0) begin
					mag = sat_mag({32'd0, mag} + d * 10);
					frac_cnt = 2'd1;
				end else if (frac_cnt == 2'd1) begin
					mag = sat_mag({32'd0, mag} + d);
					frac_cnt = 2'd2;
				end
			end
			default: begin
			end
		endcase
	endfunction

	function automatic bit decode_byte(input logic [7:0] b, input logic heavy, output res_t r);
		logic [31:0] hund;
		logic [31:0] intv;
		logic [3:0] base;
		r.status = ST_WRITE_OK;
		r.target = TGT_NONE;
		r.value = '0;
		if (b != CH_CR && b != CH_LF) begin
			if (line_len < CAP - 1) begin
				if (line_len == 0) cmd_char = b;
				else step_number(b);
				line_len++;
			end
			return 1'b0;
		end
		if (line_len == 0) return 1'b0;
		hund = apply_sign(mag);
		intv = (mag >= MAG_CAP) ? apply_sign(MAG_CAP) : apply_sign(mag / 100);
		if (force_md == MODE_ONE) base = TGT_NONE;
		else if (force_md == MODE_TWO) base = TGT_HEAVY_OFS;
		else base = heavy ? TGT_HEAVY_OFS : TGT_NONE;
		case (cmd_char)
			CH_REPORT: r.status = ST_REPORT;
			CH_KP: begin
				r.target = base + TGT_KP;
				r.value = hund;
			end
			CH_KD: begin
				r.target = base + TGT_KD;
				r.value = hund;
			end
			CH_VKP: begin
				r.target = base + TGT_VKP;
				r.value = hund;
			end
			CH_VKI: begin
				r.target = base + TGT_VKI;
				r.value = hund;
			end
			CH_LOADED: begin
				r.target = TGT_LOADED;
				r.value = hund;
			end
			CH_EMPTY: begin
				r.target = TGT_EMPTY;
				r.value = hund;
			end
			CH_FORCE: begin
				r.target = TGT_FORCE;
				r.value = intv;
				force_md = intv;
			end
			CH_TELEM: begin
				r.target = TGT_TELEM;
				r.value = intv;
				telem_md = intv;
			end
			default: r.status = ST_UNKNOWN;
		endcase
		if (r.status == ST_WRITE_OK && telem_md == MODE_TWO) r.status = ST_WRITE_SILENT;
		clear_line();
		return 1'b1;
	endfunction

	task automatic send_byte(input logic [7:0] b, input logic heavy);
		int gap;
		res_t r;
		gap = tx_idle_on ? $urandom_range(0, 3) : 0;
		repeat (gap) begin
			@(negedge clk);
			rx_ch.valid <= 1'b0;
		end
		@(negedge clk);
		rx_ch.valid <= 1'b1;
		rx_ch.rx_byte <= b;
		rx_ch.heavy_detected <= heavy;
		@(posedge clk);
		while (rx_ch.ready !== 1'b1) @(posedge clk);
		sent_cnt++;
		if (decode_byte(b, heavy, r)) line_results_q.push_back(use_typed ? typed_res : r);
	endtask

	task automatic send_text(input string s, input logic [7:0] term, input logic heavy);
		for (int i = 0; i < s.len(); i++) send_byte(s[i], 1'($urandom_range(0, 1)));
		send_byte(term, heavy);
	endtask

	task automatic send_random_line();
		logic [7:0] bytes_q [$];
		int kind;
		int n;
		logic [7:0] c;
		kind = $urandom_range(0, 99);
		if (kind < 8) begin
			n = $urandom_range(1, 30);
			repeat (n) bytes_q.push_back(8'($urandom_range(0, 255)));
		end else if (kind >= 12) begin
			if (kind < 16) begin
				c = 8'($urandom_range(0, 255));
				if (c == CH_CR || c == CH_LF) c = "x";
			end else begin
				c = CMD_SET[$urandom_range(0, 9)];
			end
			bytes_q.push_back(c);
			if ($urandom_range(0, 19) == 0) repeat (20) bytes_q.push_back(CH_SPACE);
			else repeat ($urandom_range(0, 2)) bytes_q.push_back(CH_SPACE);
			if ($urandom_range(0, 3) == 0) bytes_q.push_back(CH_MINUS);
			if ((c == CH_FORCE || c == CH_TELEM) && $urandom_range(0, 9) != 0) begin
				bytes_q.push_back(8'(CH_ZERO + $urandom_range(0, 3)));
			end else begin
				n = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 12) : $urandom_range(0, 5);
				repeat (n) bytes_q.push_back(8'(CH_ZERO + $urandom_range(0, 9)));
				if ($urandom_range(0, 1) == 1) begin
					bytes_q.push_back(CH_POINT);
					repeat ($urandom_range(0, 4)) bytes_q.push_back(8'(CH_ZERO + $urandom_range(0, 9)));
				end
			end
			if ($urandom_range(0, 6) == 0) begin
				c = 8'($urandom_range(0, 255));
				if (c != CH_CR && c != CH_LF) bytes_q.push_back(c);
				bytes_q.push_back(8'(CH_ZERO + $urandom_range(0, 9)));
			end
		end
		bytes_q.push_back(($urandom_range(0, 1) == 1) ? CH_CR : CH_LF);
		foreach (bytes_q[i]) send_byte(bytes_q[i], 1'($urandom_range(0, 1)));
	endtask

	task automatic drain_results();
		@(negedge clk);
		rx_ch.valid <= 1'b0;
		while (line_results_q.size() != 0) @(posedge clk);
	endtask

	initial begin
		int random_start;
		bit hold_done;
		bit drain_done;
		rx_ch.valid = 1'b0;
		rx_ch.rx_byte = '0;
		rx_ch.heavy_detected = 1'b0;
		arst_n = 1'b0;
		tx_idle_on = 1'b1;
		rx_idle_on = 1'b1;
		clear_line();
		force_md = '0;
		telem_md = '0;
		repeat (2) @(negedge clk);
		arst_n = 1'b1;

		foreach (dir_tab[k]) begin
			use_typed = dir_tab[k].typed;
			typed_res.status = dir_tab[k].st;
			typed_res.target = dir_tab[k].tgt;
			typed_res.value = dir_tab[k].val;
			send_text(dir_tab[k].text, dir_tab[k].term, dir_tab[k].heavy);
		end
		use_typed = 1'b0;

		random_start = sent_cnt;
		while (sent_cnt - random_start < RANDOM_ITEMS) begin
			if (!hold_done && sent_cnt - random_start >= RANDOM_ITEMS / 3) begin
				hold_req = 1'b1;
				hold_done = 1'b1;
			end
			if (!drain_done && sent_cnt - random_start >= 2 * RANDOM_ITEMS / 3) begin
				drain_results();
				drain_done = 1'b1;
			end
			if ($urandom_range(0, 19) == 0) tx_idle_on = !tx_idle_on;
			if ($urandom_range(0, 19) == 0) rx_idle_on = !rx_idle_on;
			send_random_line();
		end

		drain_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (err_cnt == 0) $display("tb: PASS");
		else $display("tb: FAIL");
		$finish;
	end

	initial begin
		int stall;
		res_t want;
		res_ch.ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			if (hold_req) begin
				repeat (LONG_HOLD) begin
					@(negedge clk);
					res_ch.ready <= 1'b0;
				end
				hold_req = 1'b0;
			end
			stall = rx_idle_on ? $urandom_range(0, 3) : 0;
			repeat (stall) begin
				@(negedge clk);
				res_ch.ready <= 1'b0;
			end
			@(negedge clk);
			res_ch.ready <= 1'b1;
			@(posedge clk);
			while (res_ch.valid !== 1'b1) @(posedge clk);
			if (line_results_q.size() == 0) begin
				$error("unexpected result beat: status %0d target %0d value %0d",
					res_ch.status, res_ch.target, res_ch.value);
				err_cnt++;
			end else begin
				want = line_results_q.pop_front();
				if (res_ch.status !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, res_ch.status);
					err_cnt++;
				end
				if (res_ch.target !== want.target) begin
					$error("target: expected %0d, got %0d", want.target, res_ch.target);
					err_cnt++;
				end
				if (res_ch.value !== want.value) begin
					$error("value: expected %0d, got %0d", want.value, res_ch.value);
					err_cnt++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n === 1'b1) begin
			if ((rx_ch.valid === 1'b1 && rx_ch.ready === 1'b1) ||
				(res_ch.valid === 1'b1 && res_ch.ready === 1'b1)) begin
				idle_cycles <= 0;
			end else if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("tb: FAIL");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

endmodule

// ----- sim.f -----
+incdir+src
src/sclp_pkg.sv
src/sclp_if.sv
src/sclp_parse.sv
src/serial_command_line_parser_unit.sv
tb/tb.sv
